// ===== hdl/assert_macros.svh =====
// Assertion macros shared by the RTL files of the sorted L1 proximal block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Condition must hold at every clock edge outside reset.
`define SL1P_ASSERT_ALWAYS(lbl, cond) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (cond)) \
        else $error("assertion failed");

// Antecedent implies consequent in the same cycle.
`define SL1P_ASSERT_IMPL(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// Antecedent implies consequent in the next cycle.
`define SL1P_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

// ===== hdl/sl1p_pkg.sv =====
// Package with widths, stack entry type and controller interface structs.
package sl1p_pkg;

    localparam int IDX_W       = 6;
    localparam int DEPTH       = 64;
    localparam int SUM_W       = 40;
    localparam int MEAN_W      = 32;
    localparam int VAL_W       = 31;
    localparam int CNT_W       = 7;
    localparam int MAX_LEN_DEF = 64;

    // One block on the stack.
    typedef struct packed {
        logic signed [SUM_W-1:0]  sum;
        logic signed [MEAN_W-1:0] mean;
        logic [IDX_W-1:0]         first;
        logic [IDX_W-1:0]         last;
    } t_entry;

    localparam int ENT_W = $bits(t_entry);

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;
        logic rd_below;
        logic merge;
        logic div_go;
        logic div_ld;
        logic push;
        logic blk_ld;
        logic emit;
        logic next_pos;
        logic next_blk;
        logic clear;
    } t_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic k_zero;
        logic le;
        logic div_done;
        logic end_flag;
        logic blk_end;
        logic last_blk;
    } t_sts;

endpackage

// ===== hdl/sl1p_ram.sv =====
// Generic single-port RAM with registered read data.
module sl1p_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_addr,
    input  logic [WIDTH-1:0]         i_wdata,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write when enabled; the read of the addressed word is registered.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        r_rdata <= r_mem[i_addr];
    end

    assign o_rdata = r_rdata;
endmodule

// ===== hdl/sl1p_div.sv =====
// Serial restoring divider: signed block sum over unsigned block length.
module sl1p_div (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_start,
    input  logic signed [sl1p_pkg::SUM_W-1:0]  i_dividend,
    input  logic [sl1p_pkg::CNT_W-1:0]         i_divisor,
    output logic                               o_done,
    output logic signed [sl1p_pkg::MEAN_W-1:0] o_quot
);
    import sl1p_pkg::*;

    logic             r_busy;
    logic [5:0]       r_cnt;
    logic             r_neg;
    logic [SUM_W-1:0] r_q;
    logic [CNT_W-1:0] r_rem;
    logic [CNT_W-1:0] r_dvs;
    logic [CNT_W:0]   shifted;
    logic [SUM_W-1:0] q_signed;

    // One quotient bit per cycle, most significant first.
    assign shifted = {r_rem, r_q[SUM_W-1]};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_cnt  <= 6'(SUM_W);
        end else if (r_busy) begin
            if (r_cnt == '0) begin
                r_busy <= 1'b0;
            end else begin
                r_cnt <= r_cnt - 6'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_neg <= i_dividend[SUM_W-1];
            r_q   <= i_dividend[SUM_W-1] ? -i_dividend : i_dividend;
            r_rem <= '0;
            r_dvs <= i_divisor;
        end else if (r_busy && r_cnt != '0) begin
            if (shifted >= {1'b0, r_dvs}) begin
                r_rem <= CNT_W'(shifted - {1'b0, r_dvs});
                r_q   <= {r_q[SUM_W-2:0], 1'b1};
            end else begin
                r_rem <= shifted[CNT_W-1:0];
                r_q   <= {r_q[SUM_W-2:0], 1'b0};
            end
        end
    end

    // Restore the sign: truncation toward zero.
    assign q_signed = r_neg ? -r_q : r_q;
    assign o_quot   = q_signed[MEAN_W-1:0];
    assign o_done   = r_busy && (r_cnt == '0);
endmodule

// ===== hdl/sl1p_ctrl.sv =====
// Controller state machine sequencing push, merge, divide and emission.
module sl1p_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_start,
    input  sl1p_pkg::t_sts  i_sts,
    output sl1p_pkg::t_cmd  o_cmd,
    output logic            o_busy
);
    import sl1p_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE, S_CHK, S_CMP, S_DGO, S_DWAIT, S_PUSH,
        S_EBLK, S_EBLD, S_EORD, S_EOUT
    } t_state;

    t_state r_state, n_state;
    t_cmd   cmd;

    // Next state and commands.
    always_comb begin
        n_state = r_state;
        cmd     = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    cmd.load = 1'b1;
                    n_state  = S_CHK;
                end
            end
            S_CHK: begin
                if (i_sts.k_zero) begin
                    n_state = S_PUSH;
                end else begin
                    cmd.rd_below = 1'b1;
                    n_state      = S_CMP;
                end
            end
            S_CMP: begin
                if (i_sts.le) begin
                    cmd.merge = 1'b1;
                    n_state   = S_DGO;
                end else begin
                    n_state = S_PUSH;
                end
            end
            S_DGO: begin
                cmd.div_go = 1'b1;
                n_state    = S_DWAIT;
            end
            S_DWAIT: begin
                if (i_sts.div_done) begin
                    cmd.div_ld = 1'b1;
                    n_state    = S_CHK;
                end
            end
            S_PUSH: begin
                cmd.push = 1'b1;
                n_state  = i_sts.end_flag ? S_EBLK : S_IDLE;
            end
            S_EBLK: begin
                n_state = S_EBLD;
            end
            S_EBLD: begin
                cmd.blk_ld = 1'b1;
                n_state    = S_EORD;
            end
            S_EORD: begin
                n_state = S_EOUT;
            end
            S_EOUT: begin
                cmd.emit = 1'b1;
                if (!i_sts.blk_end) begin
                    cmd.next_pos = 1'b1;
                    n_state      = S_EORD;
                end else if (i_sts.last_blk) begin
                    cmd.clear = 1'b1;
                    n_state   = S_IDLE;
                end else begin
                    cmd.next_blk = 1'b1;
                    n_state      = S_EBLK;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_cmd  = cmd;
    assign o_busy = (r_state != S_IDLE);

    `include "assert_macros.svh"

    // Starting the divider always leads into waiting on it.
    `SL1P_ASSERT_NEXT(a_div_after_go, r_state == S_DGO, r_state == S_DWAIT)
    // Emission starts only from a push of the final item.
    `SL1P_ASSERT_IMPL(a_emit_from_end, r_state == S_PUSH && n_state == S_EBLK, i_sts.end_flag)
endmodule

// ===== hdl/sl1p_dp.sv =====
// Datapath: block stack, order store, merge adder, divider and result registers.
module sl1p_dp #(
    parameter int MAX_LEN = sl1p_pkg::MAX_LEN_DEF
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  sl1p_pkg::t_cmd                   i_cmd,
    output sl1p_pkg::t_sts                   o_sts,
    input  logic signed [sl1p_pkg::VAL_W-1:0] i_y_value,
    input  logic signed [sl1p_pkg::VAL_W-1:0] i_lambda_value,
    input  logic [sl1p_pkg::IDX_W-1:0]       i_order_index,
    input  logic                             i_last,
    input  logic                             i_cfg_we,
    input  logic                             i_cfg_data,
    output logic                             o_valid,
    output logic [sl1p_pkg::IDX_W-1:0]       o_out_index,
    output logic [sl1p_pkg::VAL_W-1:0]       o_out_value,
    output logic                             o_out_last
);
    import sl1p_pkg::*;

    logic [IDX_W-1:0]         r_pos;
    logic [CNT_W-1:0]         r_k;
    logic signed [SUM_W-1:0]  r_top_sum;
    logic signed [MEAN_W-1:0] r_top_mean;
    logic [IDX_W-1:0]         r_top_start;
    logic [IDX_W-1:0]         r_cur_pos;
    logic                     r_end;
    logic [IDX_W-1:0]         r_j;
    logic [IDX_W-1:0]         r_i;
    logic [IDX_W-1:0]         r_blk_end;
    logic signed [MEAN_W-1:0] r_blk_mean;
    logic                     r_use_order;
    logic                     r_ov;
    logic [IDX_W-1:0]         r_oidx;
    logic [VAL_W-1:0]         r_oval;
    logic                     r_olast;

    logic signed [MEAN_W-1:0] diff;
    t_entry                   stk_wdata, stk_rdata;
    logic [IDX_W-1:0]         stk_addr, ord_addr, ord_rdata;
    logic [CNT_W-1:0]         div_len;
    logic                     div_done;
    logic signed [MEAN_W-1:0] div_quot;

    // Difference of the two sign-extended inputs.
    assign diff = MEAN_W'(i_y_value) - MEAN_W'(i_lambda_value);

    // Stack memory: push at the top, read below it or at the emit block.
    assign stk_wdata = '{sum: r_top_sum, mean: r_top_mean,
                         first: r_top_start, last: r_cur_pos};
    assign stk_addr  = i_cmd.push     ? r_k[IDX_W-1:0] :
                       i_cmd.rd_below ? r_k[IDX_W-1:0] - IDX_W'(1) : r_j;

    sl1p_ram #(.WIDTH(ENT_W), .DEPTH(DEPTH)) u_stack (
        .i_clk  (i_clk),
        .i_we   (i_cmd.push),
        .i_addr (stk_addr),
        .i_wdata(stk_wdata),
        .o_rdata(stk_rdata)
    );

    // Order store: written per item, read per emitted position.
    assign ord_addr = i_cmd.load ? r_pos : r_i;

    sl1p_ram #(.WIDTH(IDX_W), .DEPTH(DEPTH)) u_order (
        .i_clk  (i_clk),
        .i_we   (i_cmd.load),
        .i_addr (ord_addr),
        .i_wdata(i_order_index),
        .o_rdata(ord_rdata)
    );

    // Merged block length.
    assign div_len = {1'b0, r_cur_pos} - {1'b0, r_top_start} + CNT_W'(1);

    sl1p_div u_div (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_start   (i_cmd.div_go),
        .i_dividend(r_top_sum),
        .i_divisor (div_len),
        .o_done    (div_done),
        .o_quot    (div_quot)
    );

    // Control counters, the order-select flag and the output strobe.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos       <= '0;
            r_k         <= '0;
            r_j         <= '0;
            r_use_order <= 1'b0;
            r_ov        <= 1'b0;
        end else begin
            r_ov <= i_cmd.emit;
            if (i_cfg_we) begin
                r_use_order <= i_cfg_data;
            end
            if (i_cmd.load) begin
                r_pos <= r_pos + IDX_W'(1);
            end
            if (i_cmd.merge) begin
                r_k <= r_k - CNT_W'(1);
            end else if (i_cmd.push) begin
                r_k <= r_k + CNT_W'(1);
            end
            if (i_cmd.next_blk) begin
                r_j <= r_j + IDX_W'(1);
            end
            if (i_cmd.clear) begin
                r_pos <= '0;
                r_k   <= '0;
                r_j   <= '0;
            end
        end
    end

    // Top block, emission walk and result payload.
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_top_sum   <= SUM_W'(diff);
            r_top_mean  <= diff;
            r_top_start <= r_pos;
            r_cur_pos   <= r_pos;
            r_end       <= i_last || (r_pos == IDX_W'(MAX_LEN - 1));
        end
        if (i_cmd.merge) begin
            r_top_sum   <= r_top_sum + stk_rdata.sum;
            r_top_start <= stk_rdata.first;
        end
        if (i_cmd.div_ld) begin
            r_top_mean <= div_quot;
        end
        if (i_cmd.blk_ld) begin
            r_blk_mean <= stk_rdata.mean;
            r_blk_end  <= stk_rdata.last;
            r_i        <= stk_rdata.first;
        end
        if (i_cmd.next_pos) begin
            r_i <= r_i + IDX_W'(1);
        end
        if (i_cmd.emit) begin
            r_oidx  <= r_use_order ? ord_rdata : r_i;
            r_oval  <= r_blk_mean[MEAN_W-1] ? '0 : r_blk_mean[VAL_W-1:0];
            r_olast <= (r_i == r_cur_pos);
        end
    end

    // Status back to the controller.
    assign o_sts.k_zero   = (r_k == '0);
    assign o_sts.le       = (stk_rdata.mean <= r_top_mean);
    assign o_sts.div_done = div_done;
    assign o_sts.end_flag = r_end;
    assign o_sts.blk_end  = (r_i == r_blk_end);
    assign o_sts.last_blk = ({1'b0, r_j} == r_k - CNT_W'(1));

    assign o_valid     = r_ov;
    assign o_out_index = r_oidx;
    assign o_out_value = r_oval;
    assign o_out_last  = r_olast;

    `include "assert_macros.svh"

    // The stack never holds more blocks than positions.
    `SL1P_ASSERT_ALWAYS(a_k_bound, r_k <= CNT_W'(DEPTH))
    // The final result of a vector is followed by a quiet cycle.
    `SL1P_ASSERT_NEXT(a_last_quiet, r_ov && r_olast, !r_ov)
endmodule

// ===== hdl/sorted_l1_prox_pava.sv =====
// Top level of the sorted L1 proximal operator (pool adjacent violators).
//
// Input: one item per position is taken at a clock edge with start high and
// busy low: y, lambda, an order index and a last flag. The difference is
// pushed on a block stack; adjacent blocks whose means are out of order merge
// and the merged sum is divided by the block length in a serial divider.
// Per item: busy stays high while the item is pushed and any merges run, so
// the next item waits; each merge runs the merged sum through the 40-step
// divider, and merges amortize to at most one per item.
// When the last item (or the MAX_LEN-th) is done, the block walks the stack
// and puts out one result per position on o_valid for exactly one cycle:
// index, zero-clamped block mean and a last flag.
// Busy stays high until the final result is launched.
// The receiver cannot stall: each strobed result is taken as it appears.
// Configuration: a write on the cfg channel (always ready) sets use_order,
// which selects the stored order index rather than the position as index.
// Reset is synchronous, active low, and empties the stack; no clearing pass.
module sorted_l1_prox_pava #(
    parameter int MAX_LEN = sl1p_pkg::MAX_LEN_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              start,
    output logic                              busy,
    input  logic signed [sl1p_pkg::VAL_W-1:0] i_y_value,
    input  logic signed [sl1p_pkg::VAL_W-1:0] i_lambda_value,
    input  logic [sl1p_pkg::IDX_W-1:0]        i_order_index,
    input  logic                              i_last,
    input  logic                              i_cfg_valid,
    output logic                              o_cfg_ready,
    input  logic                              i_cfg_data,
    output logic                              o_valid,
    output logic [sl1p_pkg::IDX_W-1:0]        o_out_index,
    output logic [sl1p_pkg::VAL_W-1:0]        o_out_value,
    output logic                              o_out_last
);
    import sl1p_pkg::*;

    t_cmd cmd;
    t_sts sts;

    // Configuration transactions are always accepted.
    assign o_cfg_ready = 1'b1;

    sl1p_ctrl u_ctrl (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_start(start),
        .i_sts  (sts),
        .o_cmd  (cmd),
        .o_busy (busy)
    );

    sl1p_dp #(.MAX_LEN(MAX_LEN)) u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (cmd),
        .o_sts         (sts),
        .i_y_value     (i_y_value),
        .i_lambda_value(i_lambda_value),
        .i_order_index (i_order_index),
        .i_last        (i_last),
        .i_cfg_we      (i_cfg_valid),
        .i_cfg_data    (i_cfg_data),
        .o_valid       (o_valid),
        .o_out_index   (o_out_index),
        .o_out_value   (o_out_value),
        .o_out_last    (o_out_last)
    );

    `include "assert_macros.svh"

    // Mid-vector results come while the block is still busy.
    `SL1P_ASSERT_IMPL(a_busy_mid, o_valid && !o_out_last, busy)
endmodule
